>>> rtl/kbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbc_pkg: shared types and constants for the keyboard/aux controller
// Ring geometry, item kinds, command codes, status and command byte bits.
// ----------------------------------------------------------------------------
package kbc_pkg;

   localparam int RING_DEPTH = 64;
   localparam int RING_AW    = $clog2(RING_DEPTH);

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_KEY   = 2'd2,
      KIND_AUX   = 2'd3
   } kind_type;

   // status byte bit positions
   localparam int ST_OBF  = 0;
   localparam int ST_IBF  = 1;
   localparam int ST_CD   = 3;
   localparam int ST_AUXB = 5;

   // command byte bit positions
   localparam int CB_KDIS = 4;
   localparam int CB_ADIS = 5;

   // controller commands written to port 0x64
   localparam logic [7:0] CMD_READ_CB   = 8'h20;
   localparam logic [7:0] CMD_WRITE_CB  = 8'h60;
   localparam logic [7:0] CMD_AUX_DIS   = 8'hA7;
   localparam logic [7:0] CMD_AUX_EN    = 8'hA8;
   localparam logic [7:0] CMD_AUX_TEST  = 8'hA9;
   localparam logic [7:0] CMD_SELF_TEST = 8'hAA;
   localparam logic [7:0] CMD_KBD_TEST  = 8'hAB;
   localparam logic [7:0] CMD_KBD_DIS   = 8'hAD;
   localparam logic [7:0] CMD_KBD_EN    = 8'hAE;
   localparam logic [7:0] CMD_VERSION   = 8'hAF;
   localparam logic [7:0] CMD_READ_OP   = 8'hD0;
   localparam logic [7:0] CMD_WRITE_OP  = 8'hD1;
   localparam logic [7:0] CMD_A20_OFF   = 8'hDD;
   localparam logic [7:0] CMD_A20_ON    = 8'hDF;

   // keyboard commands and replies
   localparam logic [7:0] KBD_RESEND  = 8'hFE;
   localparam logic [7:0] KBD_ECHO    = 8'hEE;
   localparam logic [7:0] KBD_READ_ID = 8'hF2;
   localparam logic [7:0] KBD_ACK     = 8'hFA;
   localparam logic [7:0] KBD_ID0     = 8'hAB;
   localparam logic [7:0] KBD_ID1     = 8'h41;

   // controller replies
   localparam logic [7:0] RSP_ZERO    = 8'h00;
   localparam logic [7:0] RSP_TEST_OK = 8'h55;
   localparam logic [7:0] RSP_VERSION = 8'h01;
   localparam logic [7:0] OP_LIVE_BITS = 8'h32;
   localparam logic [7:0] OP_OBF_BIT   = 8'h10;
   localparam logic [7:0] OP_AUXB_BIT  = 8'h20;
   localparam logic [7:0] OP_A20_BIT   = 8'h02;

   // reset values
   localparam logic [7:0] RST_COMMAND  = 8'h43;
   localparam logic [7:0] RST_STATUS   = 8'h14;
   localparam logic [7:0] RST_OUT_PORT = 8'h03;

   typedef struct packed {
      kind_type   kind;
      logic       port_select;
      logic [7:0] data_in;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       kbd_irq;
      logic       aux_irq;
      logic       a20_enable;
      logic [7:0] output_port_value;
   } result_type;

   // up to three bytes pushed into a ring by one item, first in bytes[0]
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
   } push_type;

   typedef struct packed {
      logic       empty;
      logic       busy;
      logic [7:0] front;
   } ring_status_type;

   function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] i);
      if (i == RING_AW'(RING_DEPTH - 1)) begin
         return '0;
      end
      return i + 1'b1;
   endfunction

endpackage
`default_nettype wire

>>> rtl/kbc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbc_ram: generic single-port-write, single-port-read ram
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire  [$clog2(DEPTH)-1:0] waddr,
   input  wire  [WIDTH-1:0]         wdata,
   input  wire  [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> rtl/kbc_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbc_ring: byte ring with head/tail pointers and a prefetched front entry
// Extra bytes of a multi-byte push are written over the following cycles.
// ----------------------------------------------------------------------------
module kbc_ring (
   input  wire                      clock,
   input  wire                      reset,
   input  kbc_pkg::push_type        push,
   input  wire                      pop,
   output kbc_pkg::ring_status_type stat
);

   logic [kbc_pkg::RING_AW-1:0] head_ff, head_in;
   logic [kbc_pkg::RING_AW-1:0] tail_ff, tail_in;
   logic [kbc_pkg::RING_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0]                  pend_cnt_ff, pend_cnt_in;
   logic [1:0][7:0]             pend_data_ff, pend_data_in;
   logic                        byp_ff, byp_in;
   logic [7:0]                  byp_data_ff;
   logic [kbc_pkg::RING_AW-1:0] n1, n2, n3;
   logic                        push_any, pending;
   logic                        we;
   logic [kbc_pkg::RING_AW-1:0] waddr;
   logic [7:0]                  wdata;
   logic [7:0]                  ram_q;

   assign push_any = (push.count != 2'd0);
   assign pending  = (pend_cnt_ff != 2'd0);
   assign n1 = kbc_pkg::ring_next(head_ff);
   assign n2 = kbc_pkg::ring_next(n1);
   assign n3 = kbc_pkg::ring_next(n2);

   always_comb begin
      head_in      = head_ff;
      wr_ptr_in    = wr_ptr_ff;
      pend_cnt_in  = pend_cnt_ff;
      pend_data_in = pend_data_ff;
      we           = 1'b0;
      waddr        = wr_ptr_ff;
      wdata        = pend_data_ff[0];
      if (push_any) begin
         we              = 1'b1;
         waddr           = head_ff;
         wdata           = push.bytes[0];
         wr_ptr_in       = n1;
         pend_cnt_in     = push.count - 2'd1;
         pend_data_in[0] = push.bytes[1];
         pend_data_in[1] = push.bytes[2];
         case (push.count)
            2'd1:    head_in = n1;
            2'd2:    head_in = n2;
            2'd3:    head_in = n3;
            default: head_in = head_ff;
         endcase
      end else if (pending) begin
         we              = 1'b1;
         wr_ptr_in       = kbc_pkg::ring_next(wr_ptr_ff);
         pend_cnt_in     = pend_cnt_ff - 2'd1;
         pend_data_in[0] = pend_data_ff[1];
      end
   end

   assign tail_in = pop ? kbc_pkg::ring_next(tail_ff) : tail_ff;
   // front entry is fetched every cycle; a write to the same entry bypasses
   assign byp_in  = we && (waddr == tail_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         pend_cnt_ff <= 2'd0;
         byp_ff      <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         pend_cnt_ff <= pend_cnt_in;
         byp_ff      <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_ptr_ff    <= wr_ptr_in;
      pend_data_ff <= pend_data_in;
      byp_data_ff  <= wdata;
   end

   kbc_ram #(
      .WIDTH (8),
      .DEPTH (kbc_pkg::RING_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (tail_in),
      .rdata (ram_q)
   );

   assign stat.empty = (head_ff == tail_ff);
   assign stat.busy  = pending;
   assign stat.front = byp_ff ? byp_data_ff : ram_q;

   a_no_push_while_busy: assert property (@(posedge clock) disable iff (reset)
      pending |-> (push.count == 2'd0))
      else $error("ring push while extra bytes still pending");

   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      pending |-> !pop)
      else $error("ring pop while extra bytes still pending");

   a_multi_push_pends: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2 || push.count == 2'd3) |=> pending)
      else $error("multi-byte push left no pending writes");

   a_pend_count_range: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff != 2'd3)
      else $error("pending write count out of range");

endmodule
`default_nettype wire

>>> rtl/kbc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbc_core: controller registers and the per-item update
// Decodes one item against the current state and commits it on fire.
// ----------------------------------------------------------------------------
module kbc_core (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      fire,
   input  kbc_pkg::item_type        item,
   input  kbc_pkg::ring_status_type key_stat,
   input  kbc_pkg::ring_status_type aux_stat,
   output kbc_pkg::push_type        key_push,
   output logic                     key_pop,
   output kbc_pkg::push_type        aux_push,
   output logic                     aux_pop,
   output kbc_pkg::result_type      result
);

   logic [7:0] command_ff, command_in;
   logic [7:0] status_ff, status_in;
   logic [7:0] obuf_ff, obuf_in;
   logic [7:0] out_port_ff, out_port_in;
   logic [7:0] last_data_ff, last_data_in;
   logic [7:0] pend_cmd_ff, pend_cmd_in;
   logic       a20_ff, a20_in;

   logic [7:0]      rd;
   logic            irq1, irq12;
   logic            ctrl_req;
   logic [7:0]      ctrl_byte;
   logic [7:0]      op_val;
   logic [2:0][7:0] seq;
   logic [1:0]      seq_cnt;
   logic [1:0][7:0] reply;
   logic [1:0]      reply_cnt;
   logic            kpop, apop;

   always_comb begin
      command_in  = command_ff;
      status_in   = status_ff;
      obuf_in     = obuf_ff;
      out_port_in = out_port_ff;
      last_data_in = last_data_ff;
      pend_cmd_in = pend_cmd_ff;
      a20_in      = a20_ff;
      rd          = 8'h00;
      irq1        = 1'b0;
      irq12       = 1'b0;
      ctrl_req    = 1'b0;
      ctrl_byte   = kbc_pkg::RSP_ZERO;
      op_val      = out_port_ff;
      seq         = '0;
      seq_cnt     = 2'd0;
      reply       = '0;
      reply_cnt   = 2'd0;
      kpop        = 1'b0;
      apop        = 1'b0;
      aux_push    = '0;

      case (item.kind)
         kbc_pkg::KIND_READ: begin
            if (item.port_select) begin
               rd = status_ff;
            end else begin
               rd = obuf_ff;
               status_in[kbc_pkg::ST_CD] = 1'b0;
               if (status_ff[kbc_pkg::ST_AUXB]) begin
                  if (!aux_stat.empty && !command_ff[kbc_pkg::CB_ADIS]) begin
                     obuf_in = aux_stat.front;
                     apop    = 1'b1;
                     irq12   = 1'b1;
                  end else begin
                     status_in[kbc_pkg::ST_OBF]  = 1'b0;
                     status_in[kbc_pkg::ST_AUXB] = 1'b0;
                  end
               end else if (status_ff[kbc_pkg::ST_OBF]) begin
                  if (!key_stat.empty && !command_ff[kbc_pkg::CB_KDIS]) begin
                     obuf_in = key_stat.front;
                     kpop    = 1'b1;
                     irq1    = 1'b1;
                  end else begin
                     status_in[kbc_pkg::ST_OBF] = 1'b0;
                  end
               end
            end
         end
         kbc_pkg::KIND_WRITE: begin
            if (item.port_select) begin
               pend_cmd_in = item.data_in;
               status_in[kbc_pkg::ST_CD] = 1'b1;
               case (item.data_in)
                  kbc_pkg::CMD_READ_CB: begin
                     obuf_in = command_ff;
                     status_in[kbc_pkg::ST_OBF]  = 1'b1;
                     status_in[kbc_pkg::ST_IBF]  = 1'b0;
                     status_in[kbc_pkg::ST_AUXB] = 1'b0;
                  end
                  kbc_pkg::CMD_AUX_DIS:   command_in[kbc_pkg::CB_ADIS] = 1'b1;
                  kbc_pkg::CMD_AUX_EN:    command_in[kbc_pkg::CB_ADIS] = 1'b0;
                  kbc_pkg::CMD_AUX_TEST: begin
                     ctrl_req  = 1'b1;
                     ctrl_byte = kbc_pkg::RSP_ZERO;
                  end
                  kbc_pkg::CMD_SELF_TEST: begin
                     ctrl_req  = 1'b1;
                     ctrl_byte = kbc_pkg::RSP_TEST_OK;
                  end
                  kbc_pkg::CMD_KBD_TEST: begin
                     ctrl_req  = 1'b1;
                     ctrl_byte = kbc_pkg::RSP_ZERO;
                  end
                  kbc_pkg::CMD_KBD_DIS:   command_in[kbc_pkg::CB_KDIS] = 1'b1;
                  kbc_pkg::CMD_KBD_EN:    command_in[kbc_pkg::CB_KDIS] = 1'b0;
                  kbc_pkg::CMD_VERSION: begin
                     ctrl_req  = 1'b1;
                     ctrl_byte = kbc_pkg::RSP_VERSION;
                  end
                  kbc_pkg::CMD_READ_OP: begin
                     op_val = out_port_ff & ~kbc_pkg::OP_LIVE_BITS;
                     if (status_ff[kbc_pkg::ST_OBF]) op_val = op_val | kbc_pkg::OP_OBF_BIT;
                     if (status_ff[kbc_pkg::ST_AUXB]) op_val = op_val | kbc_pkg::OP_AUXB_BIT;
                     if (a20_ff) op_val = op_val | kbc_pkg::OP_A20_BIT;
                     out_port_in = op_val;
                     ctrl_req    = 1'b1;
                     ctrl_byte   = op_val;
                  end
                  kbc_pkg::CMD_A20_OFF:   a20_in = 1'b0;
                  kbc_pkg::CMD_A20_ON:    a20_in = 1'b1;
                  default: begin
                  end
               endcase
            end else if (status_ff[kbc_pkg::ST_CD]) begin
               // data byte that completes a two-byte controller command
               status_in[kbc_pkg::ST_CD] = 1'b0;
               if (pend_cmd_ff == kbc_pkg::CMD_WRITE_CB) begin
                  command_in = item.data_in;
               end else if (pend_cmd_ff == kbc_pkg::CMD_WRITE_OP) begin
                  a20_in      = item.data_in[1];
                  out_port_in = item.data_in;
               end
            end else if (!status_ff[kbc_pkg::ST_IBF]) begin
               // byte to the keyboard: build the reply sequence
               if (item.data_in == kbc_pkg::KBD_ECHO) begin
                  reply[0]  = kbc_pkg::KBD_ECHO;
                  reply_cnt = 2'd1;
               end else if (item.data_in == kbc_pkg::KBD_READ_ID) begin
                  reply[0]  = kbc_pkg::KBD_ID0;
                  reply[1]  = kbc_pkg::KBD_ID1;
                  reply_cnt = 2'd2;
               end
               if (last_data_ff == kbc_pkg::KBD_RESEND) begin
                  seq[0]  = kbc_pkg::KBD_ACK;
                  seq[1]  = reply[0];
                  seq[2]  = reply[1];
                  seq_cnt = reply_cnt + 2'd1;
               end else begin
                  seq[0]  = reply[0];
                  seq[1]  = reply[1];
                  seq_cnt = reply_cnt;
               end
               last_data_in = item.data_in;
            end
         end
         kbc_pkg::KIND_KEY: begin
            seq[0]  = item.data_in;
            seq_cnt = 2'd1;
         end
         kbc_pkg::KIND_AUX: begin
            if (command_ff[kbc_pkg::CB_ADIS] || status_ff[kbc_pkg::ST_OBF]) begin
               aux_push.count    = 2'd1;
               aux_push.bytes[0] = item.data_in;
            end else begin
               obuf_in = item.data_in;
               irq12   = 1'b1;
               status_in[kbc_pkg::ST_OBF]  = 1'b1;
               status_in[kbc_pkg::ST_AUXB] = 1'b1;
               status_in[kbc_pkg::ST_IBF]  = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // controller reply goes out only when the buffer is free
      if (ctrl_req && !status_ff[kbc_pkg::ST_OBF]) begin
         obuf_in = ctrl_byte;
         status_in[kbc_pkg::ST_OBF]  = 1'b1;
         status_in[kbc_pkg::ST_IBF]  = 1'b0;
         status_in[kbc_pkg::ST_AUXB] = 1'b0;
      end

      // keyboard bytes: the first may go straight to the buffer, the rest queue
      key_push = '0;
      if (seq_cnt != 2'd0) begin
         if (command_ff[kbc_pkg::CB_KDIS] || status_ff[kbc_pkg::ST_OBF]) begin
            key_push.count = seq_cnt;
            key_push.bytes = seq;
         end else begin
            obuf_in = seq[0];
            irq1    = 1'b1;
            status_in[kbc_pkg::ST_OBF]  = 1'b1;
            status_in[kbc_pkg::ST_IBF]  = 1'b0;
            status_in[kbc_pkg::ST_AUXB] = 1'b0;
            key_push.count    = seq_cnt - 2'd1;
            key_push.bytes[0] = seq[1];
            key_push.bytes[1] = seq[2];
            key_push.bytes[2] = 8'h00;
         end
      end

      if (!fire) begin
         key_push = '0;
         aux_push = '0;
      end
   end

   assign key_pop = fire && kpop;
   assign aux_pop = fire && apop;

   assign result.read_data         = rd;
   assign result.kbd_irq           = irq1;
   assign result.aux_irq           = irq12;
   assign result.a20_enable        = a20_in;
   assign result.output_port_value = out_port_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff   <= kbc_pkg::RST_COMMAND;
         status_ff    <= kbc_pkg::RST_STATUS;
         obuf_ff      <= 8'h00;
         out_port_ff  <= kbc_pkg::RST_OUT_PORT;
         last_data_ff <= 8'h00;
         pend_cmd_ff  <= 8'h00;
         a20_ff       <= 1'b1;
      end else if (fire) begin
         command_ff   <= command_in;
         status_ff    <= status_in;
         obuf_ff      <= obuf_in;
         out_port_ff  <= out_port_in;
         last_data_ff <= last_data_in;
         pend_cmd_ff  <= pend_cmd_in;
         a20_ff       <= a20_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/ps2_keyboard_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_keyboard_controller_top: 8042-style keyboard/aux controller
// CPU port accesses and device bytes in, one result item out per input item.
// ----------------------------------------------------------------------------
//
//  channel   dir   tdata                                   tuser
//  req_      in    data_in[7:0]                            kind[1:0], port_select[2]
//  rsp_      out   read_data[7:0], kbd_irq[8], aux_irq[9], -
//                  a20_enable[10], output_port_value[18:11]
//
//  an item is registered on accept and processed from there into the result
//  register; one item is taken per cycle unless the rings or the result stall
//  a keyboard write whose replies put two or three bytes into the keyboard
//  ring holds the next item while the extra bytes go in, one ring write port
//  a stalled result holds the pipe; the input register still takes one item
//  synchronous active-high reset; ring contents are not cleared
//
module ps2_keyboard_controller_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // data_in[7:0]
   input  wire  [2:0]  req_tuser,   // kind[1:0], port_select[2]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata    // read_data, kbd_irq, aux_irq, a20_enable,
                                    // output_port_value, zero fill
);

   // input register
   logic              item_valid_ff, item_valid_in;
   kbc_pkg::item_type item_ff, item_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [23:0]       rsp_data_ff;

   logic                     fire;
   logic                     req_accept;
   kbc_pkg::ring_status_type key_stat, aux_stat;
   kbc_pkg::push_type        key_push, aux_push;
   logic                     key_pop, aux_pop;
   kbc_pkg::result_type      result;

   // process when an item waits, the rings are not finishing a multi-byte
   // push and the result register is free or being drained
   assign fire = item_valid_ff && !key_stat.busy && !aux_stat.busy
                 && (!rsp_valid_ff || rsp_tready);

   assign req_tready = !item_valid_ff || fire;
   assign req_accept = req_tvalid && req_tready;

   assign item_in.kind        = kbc_pkg::kind_type'(req_tuser[1:0]);
   assign item_in.port_select = req_tuser[2];
   assign item_in.data_in     = req_tdata;

   assign item_valid_in = req_accept || (item_valid_ff && !fire);
   assign rsp_valid_in  = fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= item_in;
      end
      if (fire) begin
         rsp_data_ff <= {5'b00000, result.output_port_value, result.a20_enable,
                         result.aux_irq, result.kbd_irq, result.read_data};
      end
   end

   kbc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (item_ff),
      .key_stat (key_stat),
      .aux_stat (aux_stat),
      .key_push (key_push),
      .key_pop  (key_pop),
      .aux_push (aux_push),
      .aux_pop  (aux_pop),
      .result   (result)
   );

   // keyboard bytes waiting behind a full output buffer or a disabled keyboard
   kbc_ring u_key_ring (
      .clock (clock),
      .reset (reset),
      .push  (key_push),
      .pop   (key_pop),
      .stat  (key_stat)
   );

   // mouse bytes waiting behind a full output buffer or a disabled aux port
   kbc_ring u_aux_ring (
      .clock (clock),
      .reset (reset),
      .push  (aux_push),
      .pop   (aux_pop),
      .stat  (aux_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
